// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the deframer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/ebd_pkg.sv
// ----------------------------------------------------------------------------
// ebd_pkg
// types and marker constants shared by the event bag deframer
// ----------------------------------------------------------------------------
package ebd_pkg;

    localparam logic [31:0] HDR_MATCH = 32'hFBEE_FBEE;
    localparam logic [31:0] TRL_MATCH = 32'hFEDD_FEDD;

    // one result beat plus its valid flag
    typedef struct packed {
        logic        valid;
        logic [7:0]  bag_byte;
        logic        bag_last;
        logic [31:0] bag_counter;
    } bag_beat_t;

endpackage

// File: hw/rtl/ebd_frame_core.sv
// ----------------------------------------------------------------------------
// ebd_frame_core
// input register, byte history and header / trailer matching
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ebd_frame_core
    import ebd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,
    input  logic        fifo_full,
    output bag_beat_t   beat
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    logic [63:0] history_reg;
    logic [63:0] history_next;
    logic        inside_bag_reg;
    logic        inside_bag_next;
    logic        take;
    logic        advance;
    logic [31:0] recent;
    logic        trl_hit;

    assign advance  = in_valid_reg && !fifo_full;
    assign in_ready = !in_valid_reg || !fifo_full;
    assign take     = in_valid && in_ready;

    assign history_next = {history_reg[55:0], in_byte_reg};
    assign recent       = history_next[31:0];
    assign trl_hit      = (recent == TRL_MATCH);

    always_comb
    begin
        beat.valid       = advance && inside_bag_reg;
        beat.bag_byte    = in_byte_reg;
        beat.bag_last    = trl_hit;
        beat.bag_counter = trl_hit ? history_next[63:32] : 32'd0;
    end

    always_comb
    begin
        inside_bag_next = inside_bag_reg;
        if (advance)
        begin
            if (!inside_bag_reg)
            begin
                inside_bag_next = (recent == HDR_MATCH);
            end
            else if (trl_hit)
            begin
                inside_bag_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            inside_bag_reg <= 1'b0;
            history_reg    <= 64'd0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            inside_bag_reg <= inside_bag_next;
            if (advance)
            begin
                history_reg <= history_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= stream_byte;
        end
    end

    `ASSERT_NEXT(a_last_ends_bag, clk, rst_n, beat.valid && beat.bag_last, !inside_bag_reg)
    `ASSERT_IMPLIES(a_counter_zero, clk, rst_n, beat.valid && !beat.bag_last, beat.bag_counter == 32'd0)
    `ASSERT_NEXT(a_byte_held, clk, rst_n, in_valid_reg && fifo_full, in_valid_reg && $stable(in_byte_reg))

endmodule

// File: hw/rtl/ebd_out_queue.sv
// ----------------------------------------------------------------------------
// ebd_out_queue
// two-entry result queue that decouples the core from output stalls
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ebd_out_queue
    import ebd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bag_beat_t   beat,
    output logic        full,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  bag_byte,
    output logic        bag_last,
    output logic [31:0] bag_counter
);

    bag_beat_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign push      = beat.valid;
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign full      = (count_reg == 2'd2);

    assign bag_byte    = entry_reg[rd_ptr_reg].bag_byte;
    assign bag_last    = entry_reg[rd_ptr_reg].bag_last;
    assign bag_counter = entry_reg[rd_ptr_reg].bag_counter;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= beat;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full)
    `ASSERT_IMPLIES(a_count_range, clk, rst_n, 1'b1, count_reg != 2'd3)

endmodule

// File: hw/rtl/event_bag_deframer_unit.sv
// ----------------------------------------------------------------------------
// event_bag_deframer_unit
// pulls event bags out of a raw readout byte stream
// ----------------------------------------------------------------------------
// One raw byte is taken per input beat. While hunting, bytes are dropped until
// the last four read FB EE FB EE; that header is not passed on. Every later
// byte goes out as one output beat, trailer included, and the beat that
// completes the trailer FE DD FE DD has bag_last set and carries in
// bag_counter the four raw bytes just before the trailer, oldest byte most
// significant (zero on all other beats). The block then hunts again. A header
// seen inside a bag is passed on as ordinary bag data. The unit sustains one
// byte per clock while the result queue has room: each byte crosses an input
// register, 32-bit compares against an eight-byte history, and a two-entry
// result queue, so a result is registered in the input register and then in
// the queue before it reaches the output. The input stalls only while the queue
// holds two beats and the input register is loaded. in_ready depends only on
// registered state, never combinationally on out_ready.
// ----------------------------------------------------------------------------
module event_bag_deframer_unit
    import ebd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // raw byte stream
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,
    // bag beats
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  bag_byte,
    output logic        bag_last,
    output logic [31:0] bag_counter
);

    // result beat from the matcher into the queue
    bag_beat_t beat;
    // queue cannot take another beat this cycle
    logic      fifo_full;

    // input register, history shift and marker matching
    ebd_frame_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stream_byte (stream_byte),
        .fifo_full   (fifo_full),
        .beat        (beat)
    );

    // result queue, absorbs output stalls without losing a beat
    ebd_out_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat        (beat),
        .full        (fifo_full),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bag_byte    (bag_byte),
        .bag_last    (bag_last),
        .bag_counter (bag_counter)
    );

endmodule
